// File: rtl/core/sha1bs_pkg.sv
`timescale 1ns / 1ps

package sha1bs_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CV_WORDS  = 5;
  localparam int unsigned BLK_WORDS = 16;
  localparam int unsigned CV_AW     = 3;
  localparam int unsigned BLK_AW    = 4;
  localparam int unsigned T_W       = 7;

  localparam logic [T_W-1:0] LAST_ROUND = 7'd79;

  localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Item modes on the input channel
  localparam logic MODE_DATA   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // One-hot sequencer states
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HLOAD = 8'b0000_0010,
    S_ROUND = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_LENH  = 8'b0001_0000,
    S_LENL  = 8'b0010_0000,
    S_ORD   = 8'b0100_0000,
    S_OCAP  = 8'b1000_0000
  } state_e;

  // Control from the sequencer to the round datapath
  typedef struct packed {
    logic           shift;  // shift working vars, load din at e
    logic           step;   // run one compression round
    logic [T_W-1:0] t;      // round number
  } rnd_ctl_t;

  function automatic logic [WORD_W-1:0] init_value(input logic [CV_AW-1:0] idx);
    logic [WORD_W-1:0] v;
    case (idx)
      3'd0:    v = 32'h67452301;
      3'd1:    v = 32'hEFCDAB89;
      3'd2:    v = 32'h98BADCFE;
      3'd3:    v = 32'h10325476;
      3'd4:    v = 32'hC3D2E1F0;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input logic [T_W-1:0] t);
    logic [WORD_W-1:0] k;
    if (t < 7'd20) begin
      k = K0;
    end else if (t < 7'd40) begin
      k = K1;
    end else if (t < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// File: rtl/core/sha1bs_if.sv
`timescale 1ns / 1ps

interface sha1bs_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface sha1bs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last,
                  output ready);
endinterface

// File: rtl/core/sha1bs_ram.sv
`timescale 1ns / 1ps

module sha1bs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sha1bs_round.sv
`timescale 1ns / 1ps

module sha1bs_round (
  input  logic                     clk_i,
  input  sha1bs_pkg::rnd_ctl_t     ctl_i,
  input  logic [31:0]              wmem_i,
  input  logic [31:0]              din_i,
  output logic [31:0]              a_o
);

  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] w_q [sha1bs_pkg::BLK_WORDS];
  logic [31:0] wx, wsched, wt, f, tmp;

  always_comb begin
    // w_q[15] holds w[t-1]: taps for t-3, t-8, t-14, t-16
    wx     = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wsched = {wx[30:0], wx[31]};
    wt     = (ctl_i.t < 7'd16) ? wmem_i : wsched;
    if (ctl_i.t < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
    end else if (ctl_i.t < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
    end else if (ctl_i.t < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
    end else begin
      f = b_q ^ c_q ^ d_q;
    end
    tmp = {a_q[26:0], a_q[31:27]} + f + e_q + wt + sha1bs_pkg::round_k(ctl_i.t);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      a_q <= b_q;
      b_q <= c_q;
      c_q <= d_q;
      d_q <= e_q;
      e_q <= din_i;
    end else if (ctl_i.step) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      b_q <= a_q;
      a_q <= tmp;
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= wt;
    end
  end

  assign a_o = a_q;

endmodule

// File: rtl/core/sha1_byte_stream_hasher_core.sv
`timescale 1ns / 1ps

// SHA-1 hasher over a byte stream. Each data item (mode 0) packs one byte
// big-endian into a 16-word block buffer held in a RAM, and the block stays
// ready for the next byte; the 64th byte of a block starts a compression
// (load the chaining value from its RAM, 80 rounds, add the result back
// into that RAM), during which no item is accepted. Sustained throughput
// is set by the single round unit. A finish item (mode 1) appends the pad
// byte, runs an extra block when fewer than 8 bytes remain, writes the
// 64-bit bit length and runs the last block, then returns the five digest
// words in turn, H0 first, with last set on H4, each held until the sink
// has taken the one before it. The block then starts a new message from the
// initial chaining value. Valid bits on both RAMs stand for their reset
// contents, so no clearing pass is needed after reset.

module sha1_byte_stream_hasher_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sha1bs_in_if.sink            in_i,
  sha1bs_out_if.source         out_o
);

  sha1bs_pkg::state_e state_q, state_d;

  logic [2:0]  cnt_q, cnt_d;
  logic [6:0]  t_q, t_d;
  logic [5:0]  pos_q, pos_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] blk_vld_q, blk_vld_d;
  logic [4:0]  cv_vld_q, cv_vld_d;
  logic        fin_q, fin_d;
  logic        lastblk_q, lastblk_d;
  logic [2:0]  ocnt_q, ocnt_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        out_last_q, out_last_d;
  logic        out_load;

  logic        blk_rvld_q;
  logic        cv_rvld_q;
  logic [2:0]  cv_ridx_q;

  logic        blk_we, blk_re;
  logic [3:0]  blk_waddr, blk_raddr;
  logic [31:0] blk_wdata, blk_rdata, blk_rd;
  logic        cv_we, cv_re;
  logic [2:0]  cv_waddr, cv_raddr;
  logic [31:0] cv_wdata, cv_rdata, cv_rd;

  sha1bs_pkg::rnd_ctl_t rnd_ctl;
  logic [31:0]          rnd_a;

  logic        in_acc;
  logic [7:0]  byte_val;
  logic [31:0] merged;

  assign in_i.ready = (state_q == sha1bs_pkg::S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign byte_val   = (in_i.mode == sha1bs_pkg::MODE_FINISH) ? sha1bs_pkg::PAD_BYTE
                                                             : in_i.data_byte;
  // Byte lane: position 0 of a word is the most significant byte
  assign merged     = acc_q | ({24'd0, byte_val} << {~pos_q[1:0], 3'b000});

  // Unwritten entries read as their reset contents
  assign blk_rd = blk_rvld_q ? blk_rdata : '0;
  assign cv_rd  = cv_rvld_q ? cv_rdata : sha1bs_pkg::init_value(cv_ridx_q);

  sha1bs_ram #(
    .WIDTH (32),
    .DEPTH (sha1bs_pkg::BLK_WORDS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .re_i    (blk_re),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rdata)
  );

  sha1bs_ram #(
    .WIDTH (32),
    .DEPTH (sha1bs_pkg::CV_WORDS)
  ) u_cv_ram (
    .clk_i   (clk_i),
    .we_i    (cv_we),
    .waddr_i (cv_waddr),
    .wdata_i (cv_wdata),
    .re_i    (cv_re),
    .raddr_i (cv_raddr),
    .rdata_o (cv_rdata)
  );

  sha1bs_round u_round (
    .clk_i  (clk_i),
    .ctl_i  (rnd_ctl),
    .wmem_i (blk_rd),
    .din_i  (cv_rd),
    .a_o    (rnd_a)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    t_d         = t_q;
    pos_d       = pos_q;
    bitlen_d    = bitlen_q;
    acc_d       = acc_q;
    blk_vld_d   = blk_vld_q;
    cv_vld_d    = cv_vld_q;
    fin_d       = fin_q;
    lastblk_d   = lastblk_q;
    ocnt_d      = ocnt_q;
    // Drop the held item once the sink takes it
    out_valid_d = out_valid_q && !out_o.ready;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_load    = 1'b0;

    blk_we      = 1'b0;
    blk_waddr   = pos_q[5:2];
    blk_wdata   = merged;
    blk_re      = 1'b0;
    blk_raddr   = '0;
    cv_we       = 1'b0;
    cv_waddr    = cnt_q - 3'd1;
    cv_wdata    = cv_rd + rnd_a;
    cv_re       = 1'b0;
    cv_raddr    = cnt_q;
    rnd_ctl       = '0;
    rnd_ctl.t     = t_q;

    case (state_q)
      sha1bs_pkg::S_IDLE: begin
        if (in_acc) begin
          // Merge the byte (or pad byte) into its word and write it through
          blk_we               = 1'b1;
          blk_vld_d[pos_q[5:2]] = 1'b1;
          pos_d                = pos_q + 6'd1;
          acc_d                = (pos_q[1:0] == 2'd3) ? '0 : merged;
          cnt_d                = '0;
          if (in_i.mode == sha1bs_pkg::MODE_DATA) begin
            bitlen_d = bitlen_q + 64'd8;
            fin_d    = 1'b0;
            if (pos_q == 6'd63) begin
              state_d = sha1bs_pkg::S_HLOAD;
            end
          end else begin
            fin_d     = 1'b1;
            lastblk_d = 1'b0;
            // No room for the length after the pad: run this block first
            state_d   = (pos_q >= 6'd56) ? sha1bs_pkg::S_HLOAD : sha1bs_pkg::S_LENH;
          end
        end
      end

      sha1bs_pkg::S_HLOAD: begin
        // Read H0..H4 in turn, shift each into the working vars
        cv_re         = (cnt_q < 3'd5);
        rnd_ctl.shift = (cnt_q != 3'd0);
        if (cnt_q == 3'd5) begin
          blk_re    = 1'b1;
          blk_raddr = '0;
          t_d       = '0;
          state_d   = sha1bs_pkg::S_ROUND;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end

      sha1bs_pkg::S_ROUND: begin
        rnd_ctl.step = 1'b1;
        // Prefetch the next buffered word for the first 16 rounds
        if (t_q < 7'd15) begin
          blk_re    = 1'b1;
          blk_raddr = t_q[3:0] + 4'd1;
        end
        if (t_q == sha1bs_pkg::LAST_ROUND) begin
          cnt_d   = '0;
          state_d = sha1bs_pkg::S_ADD;
        end else begin
          t_d = t_q + 7'd1;
        end
      end

      sha1bs_pkg::S_ADD: begin
        // Read H[k], write back H[k-1] + working var, advance the vars
        cv_re = (cnt_q < 3'd5);
        if (cnt_q != 3'd0) begin
          cv_we              = 1'b1;
          cv_vld_d[cv_waddr] = 1'b1;
          rnd_ctl.shift      = 1'b1;
        end
        if (cnt_q == 3'd5) begin
          blk_vld_d = '0;
          pos_d     = '0;
          acc_d     = '0;
          ocnt_d    = '0;
          if (!fin_q) begin
            state_d = sha1bs_pkg::S_IDLE;
          end else if (!lastblk_q) begin
            state_d = sha1bs_pkg::S_LENH;
          end else begin
            state_d = sha1bs_pkg::S_ORD;
          end
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end

      sha1bs_pkg::S_LENH: begin
        blk_we        = 1'b1;
        blk_waddr     = 4'd14;
        blk_wdata     = bitlen_q[63:32];
        blk_vld_d[14] = 1'b1;
        state_d       = sha1bs_pkg::S_LENL;
      end

      sha1bs_pkg::S_LENL: begin
        blk_we        = 1'b1;
        blk_waddr     = 4'd15;
        blk_wdata     = bitlen_q[31:0];
        blk_vld_d[15] = 1'b1;
        bitlen_d      = '0;
        lastblk_d     = 1'b1;
        cnt_d         = '0;
        state_d       = sha1bs_pkg::S_HLOAD;
      end

      sha1bs_pkg::S_ORD: begin
        cv_re    = 1'b1;
        cv_raddr = ocnt_q;
        state_d  = sha1bs_pkg::S_OCAP;
      end

      sha1bs_pkg::S_OCAP: begin
        // Hold the read word until the output register frees up
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_word_d  = cv_rd;
          out_idx_d   = ocnt_q;
          out_last_d  = (ocnt_q == 3'd4);
          if (ocnt_q == 3'd4) begin
            // Restore the initial chaining value for the next message
            cv_vld_d  = '0;
            fin_d     = 1'b0;
            lastblk_d = 1'b0;
            state_d   = sha1bs_pkg::S_IDLE;
          end else begin
            ocnt_d  = ocnt_q + 3'd1;
            state_d = sha1bs_pkg::S_ORD;
          end
        end
      end

      default: begin
        state_d = sha1bs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha1bs_pkg::S_IDLE;
      cnt_q       <= '0;
      t_q         <= '0;
      pos_q       <= '0;
      bitlen_q    <= '0;
      acc_q       <= '0;
      blk_vld_q   <= '0;
      cv_vld_q    <= '0;
      fin_q       <= 1'b0;
      lastblk_q   <= 1'b0;
      ocnt_q      <= '0;
      out_valid_q <= 1'b0;
      blk_rvld_q  <= 1'b0;
      cv_rvld_q   <= 1'b0;
      cv_ridx_q   <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      t_q         <= t_d;
      pos_q       <= pos_d;
      bitlen_q    <= bitlen_d;
      acc_q       <= acc_d;
      blk_vld_q   <= blk_vld_d;
      cv_vld_q    <= cv_vld_d;
      fin_q       <= fin_d;
      lastblk_q   <= lastblk_d;
      ocnt_q      <= ocnt_d;
      out_valid_q <= out_valid_d;
      // Track the valid bit of each RAM read, and the index of each chaining-value read, alongside its data
      if (blk_re) begin
        blk_rvld_q <= blk_vld_q[blk_raddr];
      end
      if (cv_re) begin
        cv_rvld_q <= cv_vld_q[cv_raddr];
        cv_ridx_q <= cv_raddr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.digest_word = out_word_q;
  assign out_o.word_index  = out_idx_q;
  assign out_o.last        = out_last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1bs_pkg::S_ROUND) |-> (t_q <= sha1bs_pkg::LAST_ROUND))
    else $error("round counter past last round");

  a_no_buf_write_in_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1bs_pkg::S_ROUND) |-> !blk_we)
    else $error("block buffer written during compression");

  a_finish_restores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && ocnt_q == 3'd4) |=>
      (state_q == sha1bs_pkg::S_IDLE && pos_q == 6'd0 && bitlen_q == 64'd0 &&
       cv_vld_q == 5'd0 && blk_vld_q == 16'd0))
    else $error("state not restored after last digest word");

endmodule
